FILE: sv/sppd_pkg.sv
// Shared types, register codes and dither tables for the scanline pixel packer.
package sppd_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  typedef enum logic [2:0] {
    MODE_ARGB32  = 3'd0,
    MODE_555_HI  = 3'd1,
    MODE_555_LO  = 3'd2,
    MODE_GRAY_BE = 3'd3,
    MODE_GRAY_LE = 3'd4
  } pixel_mode_e;

  localparam logic [CfgIdxW-1:0] REG_PIXEL_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DITHER_ENABLE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_COLOR_COUNT   = 2'd2;

  localparam logic [2:0] PIXEL_MODE_RST  = 3'd0;
  localparam logic       DITHER_RST      = 1'b0;
  localparam logic [1:0] COLOR_COUNT_RST = 2'd3;
  localparam logic [1:0] COLOR_COUNT_RGB = 2'd3;

  localparam logic [7:0]  OPAQUE_ALPHA = 8'd255;
  localparam logic [8:0]  DITHER_SCALE = 9'd496;

  localparam logic [3:0] DITHER_FIRST [8] = '{
    4'd2, 4'd0, 4'd14, 4'd12, 4'd1, 4'd3, 4'd13, 4'd15
  };
  localparam logic [3:0] DITHER_SECOND [8] = '{
    4'd10, 4'd8, 4'd6, 4'd4, 4'd9, 4'd11, 4'd5, 4'd7
  };

  typedef struct packed {
    logic [2:0] pixel_mode;
    logic       dither_enable;
    logic [1:0] color_count;
  } sppd_cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] sample_a;
    logic [SampleW-1:0] sample_b;
    logic [SampleW-1:0] sample_c;
    logic [SampleW-1:0] sample_d;
    logic [SampleW-1:0] sample_e;
    logic [SampleW-1:0] sample_f;
    logic [1:0]         row_phase;
    logic               column_odd;
  } sppd_item_t;

endpackage

FILE: sv/sppd_reduce5.sv
// Reduces one 8-bit component to 5 bits by shift or by ordered dither.
module sppd_reduce5 (
  input  logic [7:0] value_i,
  input  logic       dither_i,
  input  logic [3:0] thresh_i,
  output logic [4:0] result_o
);
  import sppd_pkg::*;

  logic [16:0] product;
  logic [8:0]  scaled;
  logic [3:0]  low;
  logic [4:0]  high;

  always_comb begin
    product = {9'd0, value_i} * {8'd0, DITHER_SCALE};
    scaled  = product[16:8];
    low     = scaled[3:0];
    high    = scaled[8:4];
    if (!dither_i) begin
      result_o = value_i[7:3];
    end else if (thresh_i < low) begin
      // high is at most 30 here, so this never wraps the 5-bit field
      result_o = high + 5'd1;
    end else begin
      result_o = high;
    end
  end

endmodule

FILE: sv/sppd_pack.sv
// Combinational packing of one registered item into a frame-buffer word.
module sppd_pack (
  input  sppd_pkg::sppd_cfg_t         cfg_i,
  input  sppd_pkg::sppd_item_t        item_i,
  output logic [sppd_pkg::WordW-1:0]  word_o
);
  import sppd_pkg::*;

  logic [7:0]  r1, g1, b1, r2, g2, b2;
  logic [2:0]  sel;
  logic [3:0]  thr1, thr2;
  logic        dith;
  logic [4:0]  r1_5, g1_5, b1_5, r2_5, g2_5, b2_5;
  logic [15:0] p1, p2;

  always_comb begin
    sel  = {item_i.row_phase, item_i.column_odd};
    thr1 = DITHER_FIRST[sel];
    thr2 = DITHER_SECOND[sel];
    dith = cfg_i.dither_enable;
    if (cfg_i.color_count == COLOR_COUNT_RGB) begin
      r1 = item_i.sample_a; g1 = item_i.sample_b; b1 = item_i.sample_c;
      r2 = item_i.sample_d; g2 = item_i.sample_e; b2 = item_i.sample_f;
    end else begin
      // gray source: replicate one byte per pixel
      r1 = item_i.sample_a; g1 = item_i.sample_a; b1 = item_i.sample_a;
      r2 = item_i.sample_b; g2 = item_i.sample_b; b2 = item_i.sample_b;
    end
  end

  sppd_reduce5 u_r1 (.value_i(r1), .dither_i(dith), .thresh_i(thr1), .result_o(r1_5));
  sppd_reduce5 u_g1 (.value_i(g1), .dither_i(dith), .thresh_i(thr1), .result_o(g1_5));
  sppd_reduce5 u_b1 (.value_i(b1), .dither_i(dith), .thresh_i(thr1), .result_o(b1_5));
  sppd_reduce5 u_r2 (.value_i(r2), .dither_i(dith), .thresh_i(thr2), .result_o(r2_5));
  sppd_reduce5 u_g2 (.value_i(g2), .dither_i(dith), .thresh_i(thr2), .result_o(g2_5));
  sppd_reduce5 u_b2 (.value_i(b2), .dither_i(dith), .thresh_i(thr2), .result_o(b2_5));

  always_comb begin
    p1 = {1'b1, r1_5, g1_5, b1_5};
    p2 = {1'b1, r2_5, g2_5, b2_5};
    case (cfg_i.pixel_mode)
      MODE_ARGB32:  word_o = {OPAQUE_ALPHA, r1, g1, b1};
      MODE_555_HI:  word_o = {p1, p2};
      MODE_555_LO:  word_o = {p2, p1};
      MODE_GRAY_BE: word_o = {item_i.sample_a, item_i.sample_b,
                              item_i.sample_c, item_i.sample_d};
      MODE_GRAY_LE: word_o = {item_i.sample_d, item_i.sample_c,
                              item_i.sample_b, item_i.sample_a};
      default:      word_o = '0;
    endcase
  end

endmodule

FILE: sv/scanline_pixel_packer_dither_core.sv
// Scanline pixel packer: input register, packing logic, result register.
// An accepted word is packed from the input register into the result register.
// Throughput: one word per cycle when not stalled; set by the single packing stage.
// A stalled output holds one word and the input register holds one more before stall rises.
// Reset: asynchronous, active low; clears valids, pixel_mode 0, dither off, color_count 3.
module scanline_pixel_packer_dither_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sppd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sppd_pkg::CfgDatW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sppd_pkg::SampleW-1:0]   sample_a_i,
  input  logic [sppd_pkg::SampleW-1:0]   sample_b_i,
  input  logic [sppd_pkg::SampleW-1:0]   sample_c_i,
  input  logic [sppd_pkg::SampleW-1:0]   sample_d_i,
  input  logic [sppd_pkg::SampleW-1:0]   sample_e_i,
  input  logic [sppd_pkg::SampleW-1:0]   sample_f_i,
  input  logic [1:0]                     row_phase_i,
  input  logic                           column_odd_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sppd_pkg::WordW-1:0]     packed_word_o
);
  import sppd_pkg::*;

  sppd_cfg_t        cfg_q;
  sppd_item_t       item_q;
  logic             item_valid_q;
  logic [WordW-1:0] word_d, word_q;
  logic             word_valid_q;
  logic             out_free;
  logic             item_adv;
  logic             accept;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !word_valid_q || !out_stall_i;
  assign item_adv    = !item_valid_q || out_free;
  assign in_stall_o  = !item_adv;
  assign accept      = in_valid_i && item_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode    <= PIXEL_MODE_RST;
      cfg_q.dither_enable <= DITHER_RST;
      cfg_q.color_count   <= COLOR_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PIXEL_MODE:    cfg_q.pixel_mode    <= cfg_data_i[2:0];
        REG_DITHER_ENABLE: cfg_q.dither_enable <= cfg_data_i[0];
        REG_COLOR_COUNT:   cfg_q.color_count   <= cfg_data_i[1:0];
        default:           cfg_q               <= cfg_q; // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      word_valid_q <= 1'b0;
    end else begin
      if (item_adv) begin
        item_valid_q <= in_valid_i;
      end
      if (out_free) begin
        word_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{sample_a: sample_a_i, sample_b: sample_b_i, sample_c: sample_c_i,
                  sample_d: sample_d_i, sample_e: sample_e_i, sample_f: sample_f_i,
                  row_phase: row_phase_i, column_odd: column_odd_i};
    end
    if (out_free && item_valid_q) begin
      word_q <= word_d;
    end
  end

  sppd_pack u_pack (
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .word_o (word_d)
  );

  assign out_valid_o   = word_valid_q;
  assign packed_word_o = word_q;

endmodule

FILE: tb/sv/scanline_pixel_packer_dither_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scanline pixel packer core with ordered dither.
module scanline_pixel_packer_dither_core_tb;
  import sppd_pkg::*;

  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned WordsPerPhase = 48;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  // Predicts each packed word from the register copy and keeps the words still owed.
  class packed_word_checker;
    sppd_cfg_t   regs;
    logic [31:0] expected_words[$];
    int          errors;

    function new();
      regs.pixel_mode    = PIXEL_MODE_RST;
      regs.dither_enable = DITHER_RST;
      regs.color_count   = COLOR_COUNT_RST;
      errors             = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        REG_PIXEL_MODE:    regs.pixel_mode    = data[2:0];
        REG_DITHER_ENABLE: regs.dither_enable = data[0];
        REG_COLOR_COUNT:   regs.color_count   = data[1:0];
        default: ;
      endcase
    endfunction

    function logic [3:0] threshold(logic second, logic [2:0] sel);
      logic [3:0] first_thr, second_thr;
      case (sel)
        3'd0: begin first_thr = 4'd2;  second_thr = 4'd10; end
        3'd1: begin first_thr = 4'd0;  second_thr = 4'd8;  end
        3'd2: begin first_thr = 4'd14; second_thr = 4'd6;  end
        3'd3: begin first_thr = 4'd12; second_thr = 4'd4;  end
        3'd4: begin first_thr = 4'd1;  second_thr = 4'd9;  end
        3'd5: begin first_thr = 4'd3;  second_thr = 4'd11; end
        3'd6: begin first_thr = 4'd13; second_thr = 4'd5;  end
        default: begin first_thr = 4'd15; second_thr = 4'd7; end
      endcase
      return second ? second_thr : first_thr;
    endfunction

    function logic [4:0] to_5bit(logic [7:0] v, logic [3:0] thr);
      logic [16:0] prod;
      logic [8:0]  scaled;
      prod   = v * 17'd496;
      scaled = prod[16:8];
      if (!regs.dither_enable) return v[7:3];
      // round up when the low nibble beats the matrix entry
      if (thr < scaled[3:0]) return scaled[8:4] + 5'd1;
      return scaled[8:4];
    endfunction

    function logic [15:0] to_555(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [3:0] thr);
      return {1'b1, to_5bit(r, thr), to_5bit(g, thr), to_5bit(b, thr)};
    endfunction

    function logic [31:0] pack_word(sppd_item_t it);
      logic [7:0]  r1, g1, b1, r2, g2, b2;
      logic [2:0]  sel;
      logic [15:0] p1, p2;
      sel = {it.row_phase, it.column_odd};
      if (regs.color_count == COLOR_COUNT_RGB) begin
        r1 = it.sample_a; g1 = it.sample_b; b1 = it.sample_c;
        r2 = it.sample_d; g2 = it.sample_e; b2 = it.sample_f;
      end else begin
        r1 = it.sample_a; g1 = it.sample_a; b1 = it.sample_a;
        r2 = it.sample_b; g2 = it.sample_b; b2 = it.sample_b;
      end
      p1 = to_555(r1, g1, b1, threshold(1'b0, sel));
      p2 = to_555(r2, g2, b2, threshold(1'b1, sel));
      case (regs.pixel_mode)
        MODE_ARGB32:  return {OPAQUE_ALPHA, r1, g1, b1};
        MODE_555_HI:  return {p1, p2};
        MODE_555_LO:  return {p2, p1};
        MODE_GRAY_BE: return {it.sample_a, it.sample_b, it.sample_c, it.sample_d};
        MODE_GRAY_LE: return {it.sample_d, it.sample_c, it.sample_b, it.sample_a};
        default:      return '0;
      endcase
    endfunction

    function void note_word(sppd_item_t it);
      expected_words.push_back(pack_word(it));
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: word with none expected: expected none, actual %08h", $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (want !== got) begin
          $display("%0t: packed_word expected %08h, actual %08h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDatW-1:0]  cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_a_i   = '0;
  logic [SampleW-1:0]  sample_b_i   = '0;
  logic [SampleW-1:0]  sample_c_i   = '0;
  logic [SampleW-1:0]  sample_d_i   = '0;
  logic [SampleW-1:0]  sample_e_i   = '0;
  logic [SampleW-1:0]  sample_f_i   = '0;
  logic [1:0]          row_phase_i  = '0;
  logic                column_odd_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [WordW-1:0]    packed_word_o;

  packed_word_checker board = new();
  bit                 quiet    = 1'b0;
  bit                 hold_req = 1'b0;
  int unsigned        idle_cycles = 0;

  scanline_pixel_packer_dither_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_a_i   (sample_a_i),
    .sample_b_i   (sample_b_i),
    .sample_c_i   (sample_c_i),
    .sample_d_i   (sample_d_i),
    .sample_e_i   (sample_e_i),
    .sample_f_i   (sample_f_i),
    .row_phase_i  (row_phase_i),
    .column_odd_i (column_odd_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .packed_word_o(packed_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_word(packed_word_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("scanline_pixel_packer_dither_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && rst_ni && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgDatW-1:0] mode, input logic [CfgDatW-1:0] dith,
                           input logic [CfgDatW-1:0] colours);
    wait_drained();
    write_reg(REG_PIXEL_MODE, mode);
    write_reg(REG_DITHER_ENABLE, dith);
    write_reg(REG_COLOR_COUNT, colours);
  endtask

  task automatic send_word(input sppd_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_a_i   <= it.sample_a;
    sample_b_i   <= it.sample_b;
    sample_c_i   <= it.sample_c;
    sample_d_i   <= it.sample_d;
    sample_e_i   <= it.sample_e;
    sample_f_i   <= it.sample_f;
    row_phase_i  <= it.row_phase;
    column_odd_i <= it.column_odd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(it);
  endtask

  function automatic sppd_item_t item_of(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                         logic [7:0] d, logic [7:0] e, logic [7:0] f,
                                         logic [2:0] sel);
    sppd_item_t it;
    it = '{a, b, c, d, e, f, sel[2:1], sel[0]};
    return it;
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    sppd_item_t  it;
    logic [7:0]  mode_sel;
    logic [7:0]  colours;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: opaque argb from rgb
    send_word(item_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
    send_word(item_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
    send_word(item_of(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 3'd5));
    // index beyond the list must leave the mode alone
    wait_drained();
    write_reg(REG_UNUSED, 8'h01);
    send_word(item_of(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 3'd2));

    // dithered rgb555, walk every matrix position
    configure(8'h01, 8'h01, 8'h03);
    for (int s = 0; s < 8; s++)
      send_word(item_of(8'hFF, 8'h00, 8'h80, 8'h08, 8'h09, 8'hFA, 3'(s)));
    // gray sources into rgb555, both half orders, dither on and off
    configure(8'h02, 8'h01, 8'h01);
    send_word(item_of(8'h81, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 3'd3));
    send_word(item_of(8'hFF, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 3'd6));
    configure(8'hFA, 8'hFE, 8'h00);
    send_word(item_of(8'hC7, 8'h38, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd1));
    configure(8'h01, 8'h00, 8'h02);
    send_word(item_of(8'hF8, 8'h07, 8'h01, 8'h02, 8'h03, 8'h04, 3'd4));
    // gray packing ignores the colour count; argb with gray replication
    configure(8'h03, 8'h01, 8'h01);
    send_word(item_of(8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 3'd0));
    configure(8'h04, 8'h00, 8'h03);
    send_word(item_of(8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 3'd0));
    configure(8'h00, 8'h01, 8'h02);
    send_word(item_of(8'h5A, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
    // undefined modes give zero
    for (int m = 5; m < 8; m++) begin
      configure(8'(m), 8'h01, 8'h03);
      send_word(item_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'(m)));
    end

    for (int p = 0; p < RandPhases; p++) begin
      mode_sel = 8'($urandom_range(0, 11));
      if (mode_sel > 8'd9) mode_sel = 8'($urandom_range(5, 7));
      else if (mode_sel > 8'd4) mode_sel = 8'($urandom_range(1, 2));
      colours = 8'($urandom);
      if ($urandom_range(0, 2) != 0) colours[1:0] = COLOR_COUNT_RGB;
      configure({5'($urandom), mode_sel[2:0]}, 8'($urandom), colours);
      write_reg(REG_UNUSED, 8'($urandom));
      if (p == 3) hold_req = 1'b1;
      if (p >= RandPhases - 2) quiet = 1'b1;
      for (int n = 0; n < WordsPerPhase; n++) begin
        it.sample_a   = rand_sample();
        it.sample_b   = rand_sample();
        it.sample_c   = rand_sample();
        it.sample_d   = rand_sample();
        it.sample_e   = rand_sample();
        it.sample_f   = rand_sample();
        it.row_phase  = 2'($urandom);
        it.column_odd = 1'($urandom);
        send_word(it);
      end
    end

    wait_drained();
    repeat (6) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("scanline_pixel_packer_dither_core: match");
    end else begin
      $display("scanline_pixel_packer_dither_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sppd_pkg.sv
sv/sppd_reduce5.sv
sv/sppd_pack.sv
sv/scanline_pixel_packer_dither_core.sv
tb/sv/scanline_pixel_packer_dither_core_tb.sv
